### rtl/core/crc_framed_packet_receiver_top_assert.svh
// Assertion macros for the framed packet receiver top level.
// Included by crc_framed_packet_receiver_top.sv; needs nothing else.
`ifndef CRC_FRAMED_PACKET_RECEIVER_TOP_ASSERT_SVH
`define CRC_FRAMED_PACKET_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define CFPR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfpr assertion failed: same-cycle check");

// Next-cycle implication, checked outside reset
`define CFPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfpr assertion failed: next-cycle check");

`endif

### rtl/core/cfpr_pkg.sv
// Shared types, constants and the CRC byte update for the framed packet receiver.
// No dependencies.
package cfpr_pkg;

   // Frame sync pattern bytes
   localparam logic [7:0]  HDR_A             = 8'hAA;
   localparam logic [7:0]  HDR_B             = 8'h55;
   // CRC-16/CCITT-FALSE
   localparam logic [15:0] CRC_POLY          = 16'h1021;
   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_TOP           = 16'h8000;
   localparam logic [7:0]  MAX_PAYLOAD_RESET = 8'd250;

   // Receiver phase
   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_INFO    = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_CRC     = 2'd3
   } phase_type;

   // Result kind
   typedef enum logic [1:0] {
      KIND_DATA     = 2'd0,
      KIND_GOOD     = 2'd1,
      KIND_BAD      = 2'd2,
      KIND_OVERSIZE = 2'd3
   } kind_type;

   // Info byte position
   localparam logic [1:0] INFO_TYPE = 2'd0;
   localparam logic [1:0] INFO_SEQ  = 2'd1;
   localparam logic [1:0] INFO_LEN  = 2'd2;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic [7:0] frame_type;
      logic [7:0] frame_seq;
      logic [7:0] payload_len;
      logic [7:0] byte_index;
   } result_type;

   typedef struct packed {
      logic [1:0] count;  // words held in the result queue
      logic       space;  // a word may be pushed this cycle
   } queue_status_type;

   // One byte into the CRC, MSB first, eight shift steps
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // CRC after the four sync bytes, worked out at elaboration
   localparam logic [15:0] CRC_HDR =
      crc_feed(crc_feed(crc_feed(crc_feed(CRC_INIT, HDR_A), HDR_A), HDR_B), HDR_B);

endpackage

### rtl/core/crc_framed_packet_receiver_top.sv
// Top level of the framed packet receiver: input register, max_payload register,
// parser and result queue. Depends on cfpr_pkg, cfpr_rx_parse, cfpr_rsp_fifo.
//
//   port group  dir  handshake            word
//   req_        in   req_valid/req_ready  rx_byte
//   rsp_        out  rsp_valid/rsp_ready  kind, data_byte, frame_type, frame_seq,
//                                         payload_len, byte_index
//   csr_        in   csr_valid/csr_ready  max_payload
//
// One byte per cycle sustained while the queue has room; results are registered in the queue.
// The input register feeds the parser, which writes a two-word result queue.
// The input stage holds its byte only while the queue is full and rsp_ready is low.
// Synchronous reset returns to sync hunt with max_payload at 250; csr_ready is always high.
module crc_framed_packet_receiver_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [7:0] rsp_frame_type,
   output logic [7:0] rsp_frame_seq,
   output logic [7:0] rsp_payload_len,
   output logic [7:0] rsp_byte_index,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_max_payload
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic [7:0] max_payload_ff, max_payload_in;
   logic       in_go;
   logic       req_take;
   logic       res_valid;

   cfpr_pkg::result_type       res;
   cfpr_pkg::result_type       out_word;
   cfpr_pkg::queue_status_type q_status;

   assign csr_ready = 1'b1;
   assign in_go     = in_valid_ff && q_status.space;
   assign req_ready = !in_valid_ff || in_go;
   assign req_take  = req_valid && req_ready;

   // Input register and max_payload register
   always_comb begin
      in_valid_in    = req_take ? 1'b1 : (in_go ? 1'b0 : in_valid_ff);
      in_byte_in     = req_take ? req_rx_byte : in_byte_ff;
      max_payload_in = (csr_valid && csr_ready) ? csr_max_payload : max_payload_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         max_payload_ff <= cfpr_pkg::MAX_PAYLOAD_RESET;
      end else begin
         in_valid_ff    <= in_valid_in;
         max_payload_ff <= max_payload_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   cfpr_rx_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .in_go       (in_go),
      .in_byte     (in_byte_ff),
      .max_payload (max_payload_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   cfpr_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_word (res),
      .pop_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_word  (out_word),
      .status    (q_status)
   );

   // Result word onto the ports
   assign rsp_kind        = out_word.kind;
   assign rsp_data_byte   = out_word.data_byte;
   assign rsp_frame_type  = out_word.frame_type;
   assign rsp_frame_seq   = out_word.frame_seq;
   assign rsp_payload_len = out_word.payload_len;
   assign rsp_byte_index  = out_word.byte_index;

   // Checks
   `include "crc_framed_packet_receiver_top_assert.svh"

   `CFPR_ASSERT_IMPL(a_queue_bound, clock, reset, 1'b1, q_status.count != 2'd3)
   `CFPR_ASSERT_NEXT(a_in_hold, clock, reset, in_valid_ff && !q_status.space, in_valid_ff && $stable(in_byte_ff))
   `CFPR_ASSERT_IMPL(a_status_zero, clock, reset, rsp_valid && rsp_kind != cfpr_pkg::KIND_DATA, rsp_data_byte == 8'd0 && rsp_byte_index == 8'd0)
   `CFPR_ASSERT_IMPL(a_no_push_full, clock, reset, res_valid && q_status.count == 2'd2, rsp_ready)

endmodule

### rtl/core/cfpr_rx_parse.sv
// Frame parser: sync hunt, info bytes, payload streaming and CRC check.
// Depends on cfpr_pkg.
module cfpr_rx_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_go,
   input  logic [7:0]           in_byte,
   input  logic [7:0]           max_payload,
   output logic                 res_valid,
   output cfpr_pkg::result_type res
);

   cfpr_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [1:0]  info_idx_ff, info_idx_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  seq_ff, seq_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic        low_seen_ff, low_seen_in;
   logic [15:0] crc_ff, crc_in;

   logic [7:0]  count_inc;
   logic [15:0] crc_byte;
   logic        len_over;

   assign count_inc = count_ff + 8'd1;
   assign crc_byte  = cfpr_pkg::crc_feed(crc_ff, in_byte);
   assign len_over  = in_byte > max_payload;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (in_go) begin
         case (phase_ff)
            cfpr_pkg::PH_HUNT: begin
               if (hdr_cnt_ff == 2'd3 && in_byte == cfpr_pkg::HDR_B) begin
                  phase_in = cfpr_pkg::PH_INFO;
               end
            end
            cfpr_pkg::PH_INFO: begin
               if (info_idx_ff != cfpr_pkg::INFO_TYPE && info_idx_ff != cfpr_pkg::INFO_SEQ) begin
                  if (len_over) begin
                     phase_in = cfpr_pkg::PH_HUNT;
                  end else if (in_byte == 8'd0) begin
                     phase_in = cfpr_pkg::PH_CRC;
                  end else begin
                     phase_in = cfpr_pkg::PH_PAYLOAD;
                  end
               end
            end
            cfpr_pkg::PH_PAYLOAD: begin
               if (count_inc >= len_ff) begin
                  phase_in = cfpr_pkg::PH_CRC;
               end
            end
            cfpr_pkg::PH_CRC: begin
               if (low_seen_ff) begin
                  phase_in = cfpr_pkg::PH_HUNT;
               end
            end
            default: phase_in = cfpr_pkg::PH_HUNT;
         endcase
      end
   end

   // Frame registers and result word
   always_comb begin
      hdr_cnt_in  = hdr_cnt_ff;
      info_idx_in = info_idx_ff;
      type_in     = type_ff;
      seq_in      = seq_ff;
      len_in      = len_ff;
      count_in    = count_ff;
      crc_low_in  = crc_low_ff;
      low_seen_in = low_seen_ff;
      crc_in      = crc_ff;
      res_valid   = 1'b0;
      res.kind        = cfpr_pkg::KIND_DATA;
      res.data_byte   = 8'd0;
      res.frame_type  = type_ff;
      res.frame_seq   = seq_ff;
      res.payload_len = len_ff;
      res.byte_index  = 8'd0;
      if (in_go) begin
         case (phase_ff)
            cfpr_pkg::PH_HUNT: begin
               // a byte that breaks the match restarts on AA
               if (hdr_cnt_ff == 2'd0 && in_byte == cfpr_pkg::HDR_A) begin
                  hdr_cnt_in = 2'd1;
               end else if (hdr_cnt_ff == 2'd1 && in_byte == cfpr_pkg::HDR_A) begin
                  hdr_cnt_in = 2'd2;
               end else if (hdr_cnt_ff == 2'd2 && in_byte == cfpr_pkg::HDR_B) begin
                  hdr_cnt_in = 2'd3;
               end else if (hdr_cnt_ff == 2'd3 && in_byte == cfpr_pkg::HDR_B) begin
                  info_idx_in = cfpr_pkg::INFO_TYPE;
                  crc_in      = cfpr_pkg::CRC_HDR;
               end else begin
                  hdr_cnt_in = (in_byte == cfpr_pkg::HDR_A) ? 2'd1 : 2'd0;
               end
            end
            cfpr_pkg::PH_INFO: begin
               // info bytes go into the CRC as they arrive
               if (info_idx_ff == cfpr_pkg::INFO_TYPE) begin
                  type_in     = in_byte;
                  info_idx_in = cfpr_pkg::INFO_SEQ;
                  crc_in      = crc_byte;
               end else if (info_idx_ff == cfpr_pkg::INFO_SEQ) begin
                  seq_in      = in_byte;
                  info_idx_in = cfpr_pkg::INFO_LEN;
                  crc_in      = crc_byte;
               end else if (len_over) begin
                  res_valid       = 1'b1;
                  res.kind        = cfpr_pkg::KIND_OVERSIZE;
                  res.payload_len = in_byte;
                  hdr_cnt_in  = 2'd0;
                  info_idx_in = cfpr_pkg::INFO_TYPE;
                  type_in     = 8'd0;
                  seq_in      = 8'd0;
                  len_in      = 8'd0;
                  count_in    = 8'd0;
                  crc_low_in  = 8'd0;
                  low_seen_in = 1'b0;
                  crc_in      = cfpr_pkg::CRC_INIT;
               end else begin
                  len_in      = in_byte;
                  count_in    = 8'd0;
                  crc_low_in  = 8'd0;
                  low_seen_in = 1'b0;
                  crc_in      = crc_byte;
               end
            end
            cfpr_pkg::PH_PAYLOAD: begin
               res_valid      = 1'b1;
               res.data_byte  = in_byte;
               res.byte_index = count_ff;
               crc_in         = crc_byte;
               count_in       = count_inc;
            end
            cfpr_pkg::PH_CRC: begin
               // CRC arrives low byte first
               if (!low_seen_ff) begin
                  crc_low_in  = in_byte;
                  low_seen_in = 1'b1;
               end else begin
                  res_valid = 1'b1;
                  res.kind  = ({in_byte, crc_low_ff} == crc_ff) ?
                              cfpr_pkg::KIND_GOOD : cfpr_pkg::KIND_BAD;
                  hdr_cnt_in  = 2'd0;
                  info_idx_in = cfpr_pkg::INFO_TYPE;
                  type_in     = 8'd0;
                  seq_in      = 8'd0;
                  len_in      = 8'd0;
                  count_in    = 8'd0;
                  crc_low_in  = 8'd0;
                  low_seen_in = 1'b0;
                  crc_in      = cfpr_pkg::CRC_INIT;
               end
            end
            default: begin
               hdr_cnt_in = 2'd0;
            end
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= cfpr_pkg::PH_HUNT;
         hdr_cnt_ff  <= 2'd0;
         info_idx_ff <= cfpr_pkg::INFO_TYPE;
         type_ff     <= 8'd0;
         seq_ff      <= 8'd0;
         len_ff      <= 8'd0;
         count_ff    <= 8'd0;
         crc_low_ff  <= 8'd0;
         low_seen_ff <= 1'b0;
         crc_ff      <= cfpr_pkg::CRC_INIT;
      end else begin
         phase_ff    <= phase_in;
         hdr_cnt_ff  <= hdr_cnt_in;
         info_idx_ff <= info_idx_in;
         type_ff     <= type_in;
         seq_ff      <= seq_in;
         len_ff      <= len_in;
         count_ff    <= count_in;
         crc_low_ff  <= crc_low_in;
         low_seen_ff <= low_seen_in;
         crc_ff      <= crc_in;
      end
   end

endmodule

### rtl/core/cfpr_rsp_fifo.sv
// Two-word result queue: registers results and decouples the output stall.
// Depends on cfpr_pkg.
module cfpr_rsp_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  cfpr_pkg::result_type       push_word,
   input  logic                       pop_ready,
   output logic                       out_valid,
   output cfpr_pkg::result_type       out_word,
   output cfpr_pkg::queue_status_type status
);

   cfpr_pkg::result_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign out_valid    = count_ff != 2'd0;
   assign out_word     = mem_ff[rd_ptr_ff];
   assign pop          = out_valid && pop_ready;
   assign status.count = count_ff;
   // full queue still takes a word when the head leaves this cycle
   assign status.space = (count_ff != 2'd2) || pop_ready;

   // Pointer and fill update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage words, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for crc_framed_packet_receiver_top. It sends framed byte streams and noise,
// predicts each result word with a behavioural parser and checks the words in order.
// Depends on cfpr_pkg and the receiver RTL.
module tb;

   localparam int SETTLE_CYCLES = 8;     // quiet spell once every pending word is out
   localparam int HOLD_CYCLES   = 200;   // long result stall for the fill-up test
   localparam int STUCK_LIMIT   = 3000;  // cycles with no word moving on any port

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_data_byte;
   logic [7:0] rsp_frame_type;
   logic [7:0] rsp_frame_seq;
   logic [7:0] rsp_payload_len;
   logic [7:0] rsp_byte_index;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_max_payload = 8'h00;

   // Parser state as the testbench sees it
   cfpr_pkg::phase_type rx_phase;
   logic [1:0]  sync_count;
   logic [1:0]  info_pos;
   logic [7:0]  cur_type;
   logic [7:0]  cur_seq;
   logic [7:0]  cur_len;
   logic [7:0]  pay_count;
   logic [7:0]  crc_lo;
   logic        crc_lo_seen;
   logic [15:0] crc_acc;
   logic [7:0]  max_len;

   cfpr_pkg::result_type results_due[$];
   logic [7:0] tx_bytes[$];

   int send_idle_pct = 36;
   int rsp_idle_pct  = 88;
   int stall_asked   = 0;
   int stall_served  = 0;
   int stall_left    = 0;
   int stuck_cycles  = 0;
   int errors        = 0;
   int bytes_taken   = 0;
   int frame_bytes_sent = 0;
   int kind_count[4];

   crc_framed_packet_receiver_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_frame_type  (rsp_frame_type),
      .rsp_frame_seq   (rsp_frame_seq),
      .rsp_payload_len (rsp_payload_len),
      .rsp_byte_index  (rsp_byte_index),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_max_payload (csr_max_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // CRC-16/CCITT-FALSE, one data bit at a time into the feedback
   function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
      logic [15:0] r;
      logic        fb;
      r = c;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ d[i];
         r  = {r[14:0], 1'b0};
         if (fb) r = r ^ cfpr_pkg::CRC_POLY;
      end
      return r;
   endfunction

   task clear_frame();
      rx_phase    = cfpr_pkg::PH_HUNT;
      sync_count  = 2'd0;
      info_pos    = cfpr_pkg::INFO_TYPE;
      cur_type    = 8'h00;
      cur_seq     = 8'h00;
      cur_len     = 8'h00;
      pay_count   = 8'h00;
      crc_lo      = 8'h00;
      crc_lo_seen = 1'b0;
      crc_acc     = cfpr_pkg::CRC_INIT;
   endtask

   // Advance the parser by one received byte; queue the word it produces, if any
   task frame_parse(input logic [7:0] b);
      cfpr_pkg::result_type r;
      r = '0;
      r.frame_type  = cur_type;
      r.frame_seq   = cur_seq;
      r.payload_len = cur_len;
      case (rx_phase)
         cfpr_pkg::PH_HUNT: begin
            // a byte that breaks the match restarts it, counting an AA as the first
            if (sync_count == 2'd0 && b == cfpr_pkg::HDR_A) sync_count = 2'd1;
            else if (sync_count == 2'd1 && b == cfpr_pkg::HDR_A) sync_count = 2'd2;
            else if (sync_count == 2'd2 && b == cfpr_pkg::HDR_B) sync_count = 2'd3;
            else if (sync_count == 2'd3 && b == cfpr_pkg::HDR_B) begin
               rx_phase = cfpr_pkg::PH_INFO;
               info_pos = cfpr_pkg::INFO_TYPE;
               crc_acc  = crc16_step(cfpr_pkg::CRC_INIT, cfpr_pkg::HDR_A);
               crc_acc  = crc16_step(crc_acc, cfpr_pkg::HDR_A);
               crc_acc  = crc16_step(crc_acc, cfpr_pkg::HDR_B);
               crc_acc  = crc16_step(crc_acc, cfpr_pkg::HDR_B);
            end else begin
               sync_count = (b == cfpr_pkg::HDR_A) ? 2'd1 : 2'd0;
            end
         end
         cfpr_pkg::PH_INFO: begin
            if (info_pos == cfpr_pkg::INFO_TYPE) begin
               cur_type = b;
               info_pos = cfpr_pkg::INFO_SEQ;
            end else if (info_pos == cfpr_pkg::INFO_SEQ) begin
               cur_seq  = b;
               info_pos = cfpr_pkg::INFO_LEN;
            end else if (b > max_len) begin
               r.kind        = cfpr_pkg::KIND_OVERSIZE;
               r.payload_len = b;
               results_due.push_back(r);
               clear_frame();
            end else begin
               cur_len     = b;
               pay_count   = 8'h00;
               crc_lo_seen = 1'b0;
               crc_acc     = crc16_step(crc16_step(crc16_step(crc_acc, cur_type), cur_seq), b);
               rx_phase    = (b == 8'd0) ? cfpr_pkg::PH_CRC : cfpr_pkg::PH_PAYLOAD;
            end
         end
         cfpr_pkg::PH_PAYLOAD: begin
            r.kind       = cfpr_pkg::KIND_DATA;
            r.data_byte  = b;
            r.byte_index = pay_count;
            results_due.push_back(r);
            crc_acc   = crc16_step(crc_acc, b);
            pay_count = pay_count + 8'd1;
            if (pay_count >= cur_len) begin
               rx_phase    = cfpr_pkg::PH_CRC;
               crc_lo_seen = 1'b0;
            end
         end
         default: begin
            // CRC arrives low byte first
            if (!crc_lo_seen) begin
               crc_lo      = b;
               crc_lo_seen = 1'b1;
            end else begin
               r.kind = ({b, crc_lo} == crc_acc) ? cfpr_pkg::KIND_GOOD : cfpr_pkg::KIND_BAD;
               results_due.push_back(r);
               clear_frame();
            end
         end
      endcase
   endtask

   task check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   task check_result();
      cfpr_pkg::result_type want;
      if (results_due.size() == 0) begin
         $error("result word with nothing pending: kind %0d data %0h", rsp_kind, rsp_data_byte);
         errors++;
      end else begin
         want = results_due.pop_front();
         check_field("kind", 8'(want.kind), 8'(rsp_kind));
         check_field("data_byte", want.data_byte, rsp_data_byte);
         check_field("frame_type", want.frame_type, rsp_frame_type);
         check_field("frame_seq", want.frame_seq, rsp_frame_seq);
         check_field("payload_len", want.payload_len, rsp_payload_len);
         check_field("byte_index", want.byte_index, rsp_byte_index);
      end
   endtask

   // Monitor: register writes, accepted bytes, then result words, all at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) max_len = csr_max_payload;
         if (req_valid && req_ready) begin
            frame_parse(req_rx_byte);
            bytes_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            kind_count[rsp_kind]++;
            check_result();
         end
      end
   end

   // Result side: random idling, or a long hold-off when a test asks for one
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_served != stall_asked) begin
         stall_served = stall_asked;
         stall_left   = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Watchdog on cycles where no word moves
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // Bytes lean towards the sync values so the header logic gets exercised
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(5))
         0: return cfpr_pkg::HDR_A;
         1: return cfpr_pkg::HDR_B;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Mostly short payloads, now and then anything up to the limit
   function automatic logic [7:0] pick_len();
      int top;
      top = (max_len < 8'd12) ? int'(max_len) : 12;
      if ($urandom_range(9) == 0) return 8'($urandom_range(int'(max_len)));
      return 8'($urandom_range(top));
   endfunction

   task send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   // Whole frame into tx_bytes; flip is XORed into the CRC to corrupt it
   task build_frame(input logic [7:0] ftype, input logic [7:0] fseq, input logic [7:0] flen,
                    input logic [15:0] flip);
      logic [15:0] c;
      logic [7:0]  d;
      tx_bytes.delete();
      tx_bytes.push_back(cfpr_pkg::HDR_A);
      tx_bytes.push_back(cfpr_pkg::HDR_A);
      tx_bytes.push_back(cfpr_pkg::HDR_B);
      tx_bytes.push_back(cfpr_pkg::HDR_B);
      tx_bytes.push_back(ftype);
      tx_bytes.push_back(fseq);
      tx_bytes.push_back(flen);
      c = cfpr_pkg::CRC_INIT;
      foreach (tx_bytes[i]) c = crc16_step(c, tx_bytes[i]);
      for (int i = 0; i < int'(flen); i++) begin
         d = pick_byte();
         tx_bytes.push_back(d);
         c = crc16_step(c, d);
      end
      c = c ^ flip;
      tx_bytes.push_back(c[7:0]);
      tx_bytes.push_back(c[15:8]);
   endtask

   task send_span(input int first, input int last);
      for (int i = first; i < last; i++) begin
         send_byte(tx_bytes[i]);
         frame_bytes_sent++;
      end
   endtask

   task send_frame(input logic [7:0] ftype, input logic [7:0] fseq, input logic [7:0] flen,
                   input logic [15:0] flip);
      build_frame(ftype, fseq, flen, flip);
      send_span(0, tx_bytes.size());
   endtask

   // Stop sending and let every pending word come out, then a short quiet spell
   task settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_limit(input logic [7:0] v);
      csr_valid       <= 1'b1;
      csr_max_payload <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Field extremes, bad CRCs, oversize lengths and header restart cases
   task test_directed();
      send_idle_pct = 36;
      rsp_idle_pct  = 88;
      send_frame(8'h00, 8'hFF, 8'd0, 16'h0000);
      send_frame(8'hFF, 8'h00, 8'd1, 16'h0000);
      send_frame(8'h5A, 8'hA5, 8'd3, 16'h0001);
      send_frame(8'h01, 8'h80, 8'd2, 16'h8000);
      build_frame(8'h12, 8'h34, 8'd251, 16'h0000);
      send_span(0, 7);
      build_frame(8'hFF, 8'hFF, 8'd255, 16'h0000);
      send_span(0, 7);
      // three AAs before the 55s: no sync, the info bytes after it are ignored
      send_byte(cfpr_pkg::HDR_A);
      send_byte(cfpr_pkg::HDR_A);
      send_byte(cfpr_pkg::HDR_A);
      send_byte(cfpr_pkg::HDR_B);
      send_byte(cfpr_pkg::HDR_B);
      send_byte(8'h01);
      send_byte(8'h02);
      send_byte(8'h00);
      // sync broken one byte short, then a real frame straight after
      send_byte(cfpr_pkg::HDR_A);
      send_byte(cfpr_pkg::HDR_A);
      send_byte(cfpr_pkg::HDR_B);
      send_byte(8'h00);
      send_frame(8'h80, 8'h7F, 8'd4, 16'h0000);
      settle();
   endtask

   // max_payload at its extremes, and changes made in the middle of a frame
   task test_limits();
      write_limit(8'd0);
      send_frame(8'h10, 8'h20, 8'd0, 16'h0000);
      build_frame(8'h11, 8'h21, 8'd1, 16'h0000);
      send_span(0, 7);
      settle();
      write_limit(8'd255);
      send_frame(8'hC3, 8'h3C, 8'd255, 16'h0000);
      // length accepted under 255, limit dropped to 0 during the payload
      build_frame(8'h21, 8'h43, 8'd20, 16'h0000);
      send_span(0, 12);
      settle();
      write_limit(8'd0);
      send_span(12, tx_bytes.size());
      settle();
      // limit lowered between sequence and length bytes: length now too big
      write_limit(8'd255);
      build_frame(8'h31, 8'h32, 8'd4, 16'h0000);
      send_span(0, 6);
      settle();
      write_limit(8'd3);
      send_span(6, 7);
      settle();
      write_limit(cfpr_pkg::MAX_PAYLOAD_RESET);
      send_frame(8'h44, 8'h55, 8'd250, 16'h0000);
      build_frame(8'h45, 8'h56, 8'd251, 16'h0000);
      send_span(0, 7);
      settle();
   endtask

   // Mostly well-formed frames with random content, some broken ones and line noise
   task test_random_traffic(input int n, input int s_pct, input int r_pct, input logic [7:0] lim);
      int start;
      int r;
      send_idle_pct = s_pct;
      rsp_idle_pct  = r_pct;
      write_limit(lim);
      start = frame_bytes_sent;
      while (frame_bytes_sent - start < n) begin
         r = $urandom_range(99);
         if (r < 60) begin
            send_frame(8'($urandom), 8'($urandom), pick_len(), 16'h0000);
         end else if (r < 72) begin
            send_frame(8'($urandom), 8'($urandom), pick_len(), 16'($urandom_range(65535, 1)));
         end else if (r < 80 && max_len != 8'd255) begin
            build_frame(8'($urandom), 8'($urandom),
                        8'($urandom_range(255, int'(max_len) + 1)), 16'h0000);
            send_span(0, 7);
         end else if (r < 90) begin
            // cut short: whatever follows lands inside this frame
            build_frame(8'($urandom), 8'($urandom), pick_len(), 16'h0000);
            send_span(0, $urandom_range(tx_bytes.size() - 1, 1));
         end else begin
            repeat ($urandom_range(6, 1)) send_byte(pick_byte());
         end
      end
      settle();
   endtask

   // Result side held off while bytes keep coming, so the input stalls
   task test_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      stall_asked++;
      send_frame(8'h77, 8'h88, 8'd40, 16'h0000);
      settle();
   endtask

   initial begin
      clear_frame();
      max_len = cfpr_pkg::MAX_PAYLOAD_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_limits();
      test_random_traffic(230, 36, 88, cfpr_pkg::MAX_PAYLOAD_RESET);
      test_random_traffic(230, 88, 36, 8'($urandom_range(64, 8)));
      test_random_traffic(230, 0, 0, 8'd255);
      test_backpressure();
      if (results_due.size() != 0) begin
         $error("%0d result words never arrived", results_due.size());
         errors++;
      end
      $display("Run covered %0d bytes: %0d payload words, %0d good frames,",
               bytes_taken, kind_count[0], kind_count[1]);
      $display("%0d CRC errors, %0d oversize drops; limits 0, 3, 250, 255 and random, %0d-cycle stall",
               kind_count[2], kind_count[3], HOLD_CYCLES);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
